[rtl/core/ppp_pkg.sv]
// Shared widths, register indexes and cell payload types for the pinhole
// point projection block. No dependencies.

package ppp_pkg;

   localparam int COORD_W   = 32;  // Q16.16 coordinate
   localparam int CFG_W     = 12;  // focal length and principal point
   localparam int DIFF_W    = 33;  // difference of point and camera coordinates
   localparam int NUM_W     = 46;  // focal times camera-frame coordinate
   localparam int SUM_W     = 47;  // rounding dividend 2*num + |depth|
   localparam int DEN_W     = 34;  // divisor 2*|depth|
   localparam int MAG_W     = 46;  // dividend magnitude, one quotient bit per cell
   localparam int CLIP_W    = 18;  // quotient pre-clamped before the center add
   localparam int PIX_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int DIV_CELLS = MAG_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_U = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_V = 3'd6;

   localparam logic [COORD_W-1:0] CAMERA_RESET = 32'd131072;
   localparam logic [CFG_W-1:0]   FOCAL_RESET  = 12'd400;
   localparam logic [CFG_W-1:0]   CENTER_U_RST = 12'd190;
   localparam logic [CFG_W-1:0]   CENTER_V_RST = 12'd160;

   typedef struct packed {
      logic last;
      logic dzero;
      logic neg_u;
      logic neg_v;
   } ppp_side_type;

   typedef struct packed {
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem_u;
      logic [DEN_W-1:0] rem_v;
      logic [MAG_W-1:0] work_u;
      logic [MAG_W-1:0] work_v;
      ppp_side_type     side;
   } ppp_div_type;

endpackage

[rtl/core/ppp_front.sv]
// Front stages: camera offset and axis swap, focal multiply, sign fold,
// rounding offset and magnitude. Feeds the first divider cell. Uses ppp_pkg.

module ppp_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [ppp_pkg::COORD_W-1:0]    point_x,
   input  logic [ppp_pkg::COORD_W-1:0]    point_y,
   input  logic [ppp_pkg::COORD_W-1:0]    point_z,
   input  logic                           last_in_frame,
   input  logic [ppp_pkg::COORD_W-1:0]    camera_x,
   input  logic [ppp_pkg::COORD_W-1:0]    camera_y,
   input  logic [ppp_pkg::COORD_W-1:0]    camera_z,
   input  logic [ppp_pkg::CFG_W-1:0]      focal_x,
   input  logic [ppp_pkg::CFG_W-1:0]      focal_y,
   output logic                           out_valid,
   input  logic                           out_ready,
   output ppp_pkg::ppp_div_type           out_data
);
   import ppp_pkg::*;

   // stage a: offsets
   logic                     a_valid_ff, a_ready;
   logic signed [DIFF_W-1:0] a_xc_ff, a_yc_ff, a_zc_ff;
   logic                     a_last_ff;
   // stage b: products
   logic                     b_valid_ff, b_ready;
   logic signed [NUM_W-1:0]  b_nu_ff, b_nv_ff;
   logic signed [DIFF_W-1:0] b_zc_ff;
   logic                     b_last_ff;
   logic signed [NUM_W-1:0]  b_nu_in, b_nv_in;
   // stage c: fold depth sign into numerators
   logic                     c_valid_ff, c_ready;
   logic signed [NUM_W-1:0]  c_nu_ff, c_nv_ff;
   logic [DIFF_W-1:0]        c_ad_ff;
   logic                     c_last_ff, c_dzero_ff;
   // stage d: 2*num + |depth|, den = 2*|depth|
   logic                     d_valid_ff, d_ready;
   logic signed [SUM_W-1:0]  d_su_ff, d_sv_ff;
   logic [DEN_W-1:0]         d_den_ff;
   logic                     d_last_ff, d_dzero_ff;
   logic signed [SUM_W-1:0]  d_su_in, d_sv_in, d_ad_ext;
   // stage e: magnitudes
   logic                     e_valid_ff;
   ppp_div_type              e_data_ff;
   logic signed [SUM_W-1:0]  e_mu_in, e_mv_in;

   assign e_mu_in = d_su_ff[SUM_W-1] ? -d_su_ff : d_su_ff;
   assign e_mv_in = d_sv_ff[SUM_W-1] ? -d_sv_ff : d_sv_ff;

   assign in_ready  = !a_valid_ff || b_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign c_ready   = !c_valid_ff || d_ready;
   assign d_ready   = !d_valid_ff || a_ready;
   assign a_ready   = !e_valid_ff || out_ready;
   assign out_valid = e_valid_ff;
   assign out_data  = e_data_ff;

   assign b_nu_in = $signed({1'b0, focal_x}) * a_xc_ff;
   assign b_nv_in = $signed({1'b0, focal_y}) * a_yc_ff;

   assign d_ad_ext = $signed({{(SUM_W-DIFF_W){1'b0}}, c_ad_ff});
   assign d_su_in  = $signed({c_nu_ff, 1'b0}) + d_ad_ext;
   assign d_sv_in  = $signed({c_nv_ff, 1'b0}) + d_ad_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (in_ready) a_valid_ff <= in_valid;
         if (b_ready)  b_valid_ff <= a_valid_ff;
         if (c_ready)  c_valid_ff <= b_valid_ff;
         if (d_ready)  d_valid_ff <= c_valid_ff;
         if (a_ready)  e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         a_xc_ff   <= $signed({point_y[COORD_W-1], point_y})
                    - $signed({camera_y[COORD_W-1], camera_y});
         a_yc_ff   <= $signed({camera_z[COORD_W-1], camera_z})
                    - $signed({point_z[COORD_W-1], point_z});
         a_zc_ff   <= $signed({camera_x[COORD_W-1], camera_x})
                    - $signed({point_x[COORD_W-1], point_x});
         a_last_ff <= last_in_frame;
      end
      if (b_ready) begin
         b_nu_ff   <= b_nu_in;
         b_nv_ff   <= b_nv_in;
         b_zc_ff   <= a_zc_ff;
         b_last_ff <= a_last_ff;
      end
      if (c_ready) begin
         c_nu_ff    <= b_zc_ff[DIFF_W-1] ? -b_nu_ff : b_nu_ff;
         c_nv_ff    <= b_zc_ff[DIFF_W-1] ? -b_nv_ff : b_nv_ff;
         c_ad_ff    <= b_zc_ff[DIFF_W-1] ? DIFF_W'(-b_zc_ff) : DIFF_W'(b_zc_ff);
         c_dzero_ff <= (b_zc_ff == '0);
         c_last_ff  <= b_last_ff;
      end
      if (d_ready) begin
         d_su_ff    <= d_su_in;
         d_sv_ff    <= d_sv_in;
         d_den_ff   <= {c_ad_ff, 1'b0};
         d_dzero_ff <= c_dzero_ff;
         d_last_ff  <= c_last_ff;
      end
      if (a_ready) begin
         e_data_ff.den        <= d_den_ff;
         e_data_ff.rem_u      <= '0;
         e_data_ff.rem_v      <= '0;
         e_data_ff.work_u     <= e_mu_in[MAG_W-1:0];
         e_data_ff.work_v     <= e_mv_in[MAG_W-1:0];
         e_data_ff.side.last  <= d_last_ff;
         e_data_ff.side.dzero <= d_dzero_ff;
         e_data_ff.side.neg_u <= d_su_ff[SUM_W-1];
         e_data_ff.side.neg_v <= d_sv_ff[SUM_W-1];
      end
   end

endmodule

[rtl/core/ppp_div_cell.sv]
// One divider cell: develops one quotient bit for the column and row lanes
// against the shared divisor and hands the item on. Uses ppp_pkg.

module ppp_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ppp_pkg::ppp_div_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ppp_pkg::ppp_div_type out_data
);
   import ppp_pkg::*;

   logic              valid_ff;
   ppp_div_type       data_ff, data_in;
   logic [DEN_W:0]    try_u, try_v;
   logic [DEN_W:0]    diff_u, diff_v;
   logic              borrow_u, borrow_v;

   always_comb begin
      try_u = {in_data.rem_u, in_data.work_u[MAG_W-1]};
      try_v = {in_data.rem_v, in_data.work_v[MAG_W-1]};
      {borrow_u, diff_u} = {1'b0, try_u} - {2'b00, in_data.den};
      {borrow_v, diff_v} = {1'b0, try_v} - {2'b00, in_data.den};
      data_in        = in_data;
      data_in.rem_u  = borrow_u ? try_u[DEN_W-1:0] : diff_u[DEN_W-1:0];
      data_in.rem_v  = borrow_v ? try_v[DEN_W-1:0] : diff_v[DEN_W-1:0];
      data_in.work_u = {in_data.work_u[MAG_W-2:0], !borrow_u};
      data_in.work_v = {in_data.work_v[MAG_W-2:0], !borrow_v};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/core/ppp_back.sv]
// Back stages: floor correction of the quotient, pre-clamp, principal point
// add, 16-bit saturation, frame test and the result register. Uses ppp_pkg.

module ppp_back #(
   parameter int FRAME_WIDTH  = 1680,
   parameter int FRAME_HEIGHT = 1080
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  ppp_pkg::ppp_div_type         in_data,
   input  logic [ppp_pkg::CFG_W-1:0]    center_u,
   input  logic [ppp_pkg::CFG_W-1:0]    center_v,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ppp_pkg::PIX_W-1:0]    pixel_u,
   output logic [ppp_pkg::PIX_W-1:0]    pixel_v,
   output logic                         on_image,
   output logic                         depth_zero,
   output logic                         frame_end
);
   import ppp_pkg::*;

   localparam logic signed [MAG_W:0]    QMAX = (MAG_W+1)'(2 ** (CLIP_W - 1) - 1);
   localparam logic signed [MAG_W:0]    QMIN = -(MAG_W+1)'(2 ** (CLIP_W - 1));
   localparam logic signed [CLIP_W:0]   PMAX = (CLIP_W+1)'(2 ** (PIX_W - 1) - 1);
   localparam logic signed [CLIP_W:0]   PMIN = -(CLIP_W+1)'(2 ** (PIX_W - 1));
   localparam logic [PIX_W-1:0]         FW   = PIX_W'(FRAME_WIDTH);
   localparam logic [PIX_W-1:0]         FH   = PIX_W'(FRAME_HEIGHT);

   function automatic logic signed [CLIP_W-1:0] floor_clip(
      input logic [MAG_W-1:0] mag,
      input logic [DEN_W-1:0] rem,
      input logic             neg
   );
      logic signed [MAG_W:0] q;
      q = neg ? $signed({1'b1, ~mag}) + $signed({{MAG_W{1'b0}}, rem == '0})
              : $signed({1'b0, mag});
      if (q > QMAX) q = QMAX;
      if (q < QMIN) q = QMIN;
      return q[CLIP_W-1:0];
   endfunction

   function automatic logic [PIX_W-1:0] add_center(
      input logic signed [CLIP_W-1:0] q,
      input logic [CFG_W-1:0]         ctr
   );
      logic signed [CLIP_W:0] s;
      s = $signed({q[CLIP_W-1], q})
        + $signed({{(CLIP_W+1-CFG_W){1'b0}}, ctr});
      if (s > PMAX) s = PMAX;
      if (s < PMIN) s = PMIN;
      return s[PIX_W-1:0];
   endfunction

   logic                     s_valid_ff, s_ready;
   logic signed [CLIP_W-1:0] s_qu_ff, s_qv_ff;
   logic                     s_last_ff, s_dzero_ff;
   logic                     o_valid_ff;
   logic [PIX_W-1:0]         o_u_ff, o_v_ff;
   logic                     o_on_ff, o_dzero_ff, o_last_ff;
   logic [PIX_W-1:0]         o_u_in, o_v_in;
   logic                     o_on_in;

   assign o_u_in  = s_dzero_ff ? '0 : add_center(s_qu_ff, center_u);
   assign o_v_in  = s_dzero_ff ? '0 : add_center(s_qv_ff, center_v);
   assign o_on_in = !s_dzero_ff && !o_u_in[PIX_W-1] && (o_u_in < FW)
                 && !o_v_in[PIX_W-1] && (o_v_in < FH);

   assign in_ready   = !s_valid_ff || s_ready;
   assign s_ready    = !o_valid_ff || rsp_ready;
   assign rsp_valid  = o_valid_ff;
   assign pixel_u    = o_u_ff;
   assign pixel_v    = o_v_ff;
   assign on_image   = o_on_ff;
   assign depth_zero = o_dzero_ff;
   assign frame_end  = o_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (in_ready) s_valid_ff <= in_valid;
         if (s_ready)  o_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         s_qu_ff    <= floor_clip(in_data.work_u, in_data.rem_u, in_data.side.neg_u);
         s_qv_ff    <= floor_clip(in_data.work_v, in_data.rem_v, in_data.side.neg_v);
         s_dzero_ff <= in_data.side.dzero;
         s_last_ff  <= in_data.side.last;
      end
      if (s_ready) begin
         o_u_ff     <= o_u_in;
         o_v_ff     <= o_v_in;
         o_on_ff    <= o_on_in;
         o_dzero_ff <= s_dzero_ff;
         o_last_ff  <= s_last_ff;
      end
   end

endmodule

[rtl/core/pinhole_point_projection.sv]
// Pinhole point projection, top level: camera registers, front stages,
// a row of divider cells and the back stages. Uses ppp_pkg and all ppp_ modules.
//
// Usage:
//  req_ channel: one world point per item, tdata = {point_z, point_y, point_x},
//  each signed Q16.16; tlast marks the last point of a frame.
//  rsp_ channel: one result per point, tdata = {pixel_v, pixel_u}, signed
//  16-bit pixels; tuser = {depth_zero, on_image}; tlast copies the point's tlast.
//  csr_ channel: register index 0..6 = camera_x, camera_y, camera_z, focal_x,
//  focal_y, center_u, center_v; other indexes are ignored. csr_ready is always
//  high; write only while no point is in flight.
//  From input accept to result valid an item passes 5 front stages, 46 divider
//  cells (one quotient bit each) and 2 back stages; the divider row is most of
//  that path. One point is accepted every cycle unless rsp_ is stalled.
//  Every stage holds its item while the next one is full, so a stalled rsp_
//  side fills empty stages first and only then drops req_tready.
//  Reset (synchronous, active high) empties the pipeline and loads the
//  default camera at (2,2,2), focal lengths 400 and principal point (190,160).

module pinhole_point_projection #(
   parameter int FRAME_WIDTH  = 1680,
   parameter int FRAME_HEIGHT = 1080
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [3*ppp_pkg::COORD_W-1:0]     req_tdata,  // point_x, point_y, point_z
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [2*ppp_pkg::PIX_W-1:0]       rsp_tdata,  // pixel_u, pixel_v
   output logic [1:0]                        rsp_tuser,  // on_image, depth_zero
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ppp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ppp_pkg::COORD_W-1:0]       csr_data
);
   import ppp_pkg::*;

   logic [COORD_W-1:0] camera_x_ff, camera_y_ff, camera_z_ff;
   logic [CFG_W-1:0]   focal_x_ff, focal_y_ff, center_u_ff, center_v_ff;

   logic        cell_valid [DIV_CELLS+1];
   logic        cell_ready [DIV_CELLS+1];
   ppp_div_type cell_data  [DIV_CELLS+1];

   logic [PIX_W-1:0] pixel_u, pixel_v;
   logic             on_image, depth_zero;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_x_ff <= CAMERA_RESET;
         camera_y_ff <= CAMERA_RESET;
         camera_z_ff <= CAMERA_RESET;
         focal_x_ff  <= FOCAL_RESET;
         focal_y_ff  <= FOCAL_RESET;
         center_u_ff <= CENTER_U_RST;
         center_v_ff <= CENTER_V_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CAMERA_X: camera_x_ff <= csr_data;
            CSR_CAMERA_Y: camera_y_ff <= csr_data;
            CSR_CAMERA_Z: camera_z_ff <= csr_data;
            CSR_FOCAL_X:  focal_x_ff  <= csr_data[CFG_W-1:0];
            CSR_FOCAL_Y:  focal_y_ff  <= csr_data[CFG_W-1:0];
            CSR_CENTER_U: center_u_ff <= csr_data[CFG_W-1:0];
            CSR_CENTER_V: center_v_ff <= csr_data[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   ppp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .point_x       (req_tdata[COORD_W-1:0]),
      .point_y       (req_tdata[2*COORD_W-1:COORD_W]),
      .point_z       (req_tdata[3*COORD_W-1:2*COORD_W]),
      .last_in_frame (req_tlast),
      .camera_x      (camera_x_ff),
      .camera_y      (camera_y_ff),
      .camera_z      (camera_z_ff),
      .focal_x       (focal_x_ff),
      .focal_y       (focal_y_ff),
      .out_valid     (cell_valid[0]),
      .out_ready     (cell_ready[0]),
      .out_data      (cell_data[0])
   );

   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
      ppp_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[i]),
         .in_ready  (cell_ready[i]),
         .in_data   (cell_data[i]),
         .out_valid (cell_valid[i+1]),
         .out_ready (cell_ready[i+1]),
         .out_data  (cell_data[i+1])
      );
   end

   ppp_back #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (cell_valid[DIV_CELLS]),
      .in_ready   (cell_ready[DIV_CELLS]),
      .in_data    (cell_data[DIV_CELLS]),
      .center_u   (center_u_ff),
      .center_v   (center_v_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .pixel_u    (pixel_u),
      .pixel_v    (pixel_v),
      .on_image   (on_image),
      .depth_zero (depth_zero),
      .frame_end  (rsp_tlast)
   );

   assign rsp_tdata = {pixel_v, pixel_u};
   assign rsp_tuser = {depth_zero, on_image};

endmodule
